FILE: rtl/gldc_pkg.sv
// Shared types, codes and constants for the gesture lamp dimmer controller.
// No dependencies; imported by every module of the block.
`default_nettype none
package gldc_pkg;

	localparam int unsigned ScoreW  = 16;
	localparam int unsigned BrightW = 10;
	localparam int unsigned RatioW  = 7;
	localparam int unsigned LevelW  = 4;
	localparam int unsigned IdleW   = 4;
	localparam int unsigned ProgW   = 2;
	localparam int unsigned OffIdleW = 3;
	localparam int unsigned PwmW    = 9;
	localparam int unsigned CodeW   = 2;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned ProdW   = BrightW + RatioW;

	localparam logic [ScoreW-1:0] THR_STRONG_RST = 16'd64881;
	localparam logic [ScoreW-1:0] THR_COLOR_RST  = 16'd62259;
	localparam logic [ScoreW-1:0] THR_POWER_RST  = 16'd58982;

	localparam logic [CfgIdxW-1:0] CFG_THR_STRONG = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_THR_COLOR  = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_THR_POWER  = 2'd2;

	localparam logic [LevelW-1:0] LVL_ASLEEP  = 4'd0;
	localparam logic [LevelW-1:0] LVL_WAKING  = 4'd1;
	localparam logic [LevelW-1:0] LVL_AWAKE   = 4'd2;
	localparam logic [LevelW-1:0] LVL_JUST_ON = 4'd10;

	localparam logic [CodeW-1:0] BEEP_NONE   = 2'd0;
	localparam logic [CodeW-1:0] BEEP_SINGLE = 2'd1;
	localparam logic [CodeW-1:0] BEEP_DOUBLE = 2'd2;
	localparam logic [CodeW-1:0] BEEP_LONG   = 2'd3;

	localparam logic [CodeW-1:0] STOP_NONE   = 2'd0;
	localparam logic [CodeW-1:0] STOP_BRIGHT = 2'd1;
	localparam logic [CodeW-1:0] STOP_COLOR  = 2'd2;

	localparam logic [BrightW-1:0] BRIGHT_ON  = 10'd250;
	localparam logic [RatioW-1:0]  RATIO_FULL = 7'd100;
	localparam logic [RatioW-1:0]  RATIO_HALF = 7'd50;
	localparam logic [RatioW-1:0]  COLOR_STEP = 7'd50;
	localparam logic [IdleW-1:0]   WAKE1_LIMIT = 4'd5;
	localparam logic [IdleW-1:0]   WAKE2_LIMIT = 4'd10;
	localparam logic [OffIdleW-1:0] OFF_IDLE_LIMIT = 3'd5;

	// signed working width for the brightness bounce
	localparam int unsigned BrSW = BrightW + 2;
	localparam logic signed [BrSW-1:0] BRIGHT_STEP = 12'sd200;
	localparam logic signed [BrSW-1:0] BRIGHT_MAX  = 12'sd500;
	localparam logic signed [BrSW-1:0] BRIGHT_MIN  = 12'sd100;

	// floor(x / 100) for x below 43699: (x * RECIP_100) >> RECIP_SH
	localparam int unsigned RecipW = 16;
	localparam int unsigned RECIP_SH = 22;
	localparam logic [RecipW-1:0] RECIP_100 = 16'd41944;

	typedef struct packed {
		logic [BrightW-1:0] bright;
		logic [RatioW-1:0]  ratio_warm;
		logic [RatioW-1:0]  ratio_cool;
		logic [CodeW-1:0]   beep;
		logic [CodeW-1:0]   stop;
	} gldc_res_t;

endpackage
`default_nettype wire

FILE: rtl/gldc_ctrl.sv
// Gesture decision and lamp state: threshold registers, wake and idle
// tracking, brightness and colour bounce. Depends on gldc_pkg.
`default_nettype none
module gldc_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [gldc_pkg::ScoreW-1:0]   bright_score_a,
	input  wire logic [gldc_pkg::ScoreW-1:0]   color_score_a,
	input  wire logic [gldc_pkg::ScoreW-1:0]   power_score_a,
	input  wire logic [gldc_pkg::ScoreW-1:0]   bright_score_b,
	input  wire logic [gldc_pkg::ScoreW-1:0]   color_score_b,
	input  wire logic [gldc_pkg::ScoreW-1:0]   power_score_b,
	input  wire logic                          cfg_we,
	input  wire logic [gldc_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [gldc_pkg::ScoreW-1:0]   cfg_data,
	output gldc_pkg::gldc_res_t                res
);
	import gldc_pkg::*;

	logic [ScoreW-1:0]   thr_strong_q, thr_color_q, thr_power_q;
	logic                lamp_on_q, lamp_on_d;
	logic [LevelW-1:0]   level_q, level_d;
	logic [IdleW-1:0]    idle_q, idle_d;
	logic [ProgW-1:0]    prog_q, prog_d;
	logic [OffIdleW-1:0] off_idle_q, off_idle_d;
	logic [BrightW-1:0]  bright_q, bright_d;
	logic                br_down_q, br_down_d;
	logic                col_back_q, col_back_d;
	logic [RatioW-1:0]   rw_q, rw_d, rc_q, rc_d;
	logic [CodeW-1:0]    beep, stop;

	logic br_s, co_s, pw_s, co_c, pw_p, motion;
	logic signed [BrSW-1:0] br_step;
	logic                   br_step_down;
	logic [RatioW-1:0]      rw_step, rc_step;
	logic                   col_step_back;

	function automatic logic [RatioW-1:0] up_ratio(input logic [RatioW-1:0] r);
		logic [RatioW:0] s;
		s = {1'b0, r} + {1'b0, COLOR_STEP};
		return (s > {1'b0, RATIO_FULL}) ? RATIO_FULL : s[RatioW-1:0];
	endfunction

	function automatic logic [RatioW-1:0] down_ratio(input logic [RatioW-1:0] r);
		return (r < COLOR_STEP) ? '0 : r - COLOR_STEP;
	endfunction

	assign br_s = (bright_score_a > thr_strong_q) && (bright_score_b > thr_strong_q);
	assign co_s = (color_score_a > thr_strong_q) && (color_score_b > thr_strong_q);
	assign pw_s = (power_score_a > thr_strong_q) && (power_score_b > thr_strong_q);
	assign co_c = (color_score_a > thr_color_q) && (color_score_b > thr_color_q);
	assign pw_p = (power_score_a > thr_power_q) && (power_score_b > thr_power_q);
	assign motion = br_s || co_s || pw_s;

	always_comb begin
		logic signed [BrSW-1:0] b;
		b = $signed({2'b00, bright_q});
		br_step = br_down_q ? b - BRIGHT_STEP : b + BRIGHT_STEP;
		br_step_down = br_down_q;
		if (br_step > BRIGHT_MAX) begin
			br_step_down = 1'b1;
			br_step = BRIGHT_MAX;
		end
		if (br_step < BRIGHT_MIN) begin
			br_step_down = 1'b0;
			br_step = BRIGHT_MIN;
		end
	end

	always_comb begin
		if (!col_back_q) begin
			rw_step = up_ratio(rw_q);
			rc_step = down_ratio(rc_q);
		end else begin
			rc_step = up_ratio(rc_q);
			rw_step = down_ratio(rw_q);
		end
		col_step_back = col_back_q;
		if (rw_step == RATIO_FULL && rc_step == '0)
			col_step_back = 1'b1;
		else if (rc_step == RATIO_FULL && rw_step == '0)
			col_step_back = 1'b0;
	end

	always_comb begin
		lamp_on_d  = lamp_on_q;
		level_d    = level_q;
		idle_d     = idle_q;
		prog_d     = prog_q;
		off_idle_d = off_idle_q;
		bright_d   = bright_q;
		br_down_d  = br_down_q;
		col_back_d = col_back_q;
		rw_d       = rw_q;
		rc_d       = rc_q;
		beep       = BEEP_NONE;
		stop       = STOP_NONE;
		if (lamp_on_q) begin
			if (!motion) begin
				if (level_q == LVL_WAKING) begin
					idle_d = idle_q + 1'b1;
					if (idle_d >= WAKE1_LIMIT) begin
						idle_d  = '0;
						level_d = LVL_ASLEEP;
					end
				end else if (level_q == LVL_AWAKE) begin
					idle_d = idle_q + 1'b1;
					if (idle_d > WAKE2_LIMIT) begin
						idle_d  = '0;
						level_d = LVL_ASLEEP;
					end
				end
			end else if (level_q != LVL_ASLEEP) begin
				if (br_s) begin
					bright_d  = br_step[BrightW-1:0];
					br_down_d = br_step_down;
					beep      = BEEP_SINGLE;
					stop      = STOP_BRIGHT;
					level_d   = LVL_AWAKE;
				end else if (co_c) begin
					rw_d       = rw_step;
					rc_d       = rc_step;
					col_back_d = col_step_back;
					beep       = BEEP_DOUBLE;
					stop       = STOP_COLOR;
					level_d    = LVL_AWAKE;
				end else if (pw_p) begin
					level_d = LVL_AWAKE;
					if (level_q != LVL_JUST_ON) begin
						bright_d  = '0;
						rw_d      = RATIO_HALF;
						rc_d      = RATIO_HALF;
						prog_d    = '0;
						lamp_on_d = 1'b0;
						beep      = BEEP_LONG;
					end
				end
			end else begin
				if (br_s || co_c) begin
					level_d = LVL_WAKING;
				end else if (pw_p) begin
					level_d = LVL_WAKING;
					prog_d  = '0;
					beep    = BEEP_LONG;
				end
			end
		end else begin
			if (!motion) begin
				if (prog_q == ProgW'(1)) begin
					off_idle_d = off_idle_q + 1'b1;
					if (off_idle_d >= OFF_IDLE_LIMIT) begin
						off_idle_d = '0;
						prog_d     = '0;
					end
				end
			end else if (pw_p && prog_q < ProgW'(2)) begin
				prog_d = prog_q + 1'b1;
				beep   = BEEP_LONG;
				if (prog_d >= ProgW'(2)) begin
					bright_d   = BRIGHT_ON;
					rw_d       = RATIO_HALF;
					rc_d       = RATIO_HALF;
					lamp_on_d  = 1'b1;
					off_idle_d = '0;
					prog_d     = '0;
					level_d    = LVL_JUST_ON;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_strong_q <= THR_STRONG_RST;
			thr_color_q  <= THR_COLOR_RST;
			thr_power_q  <= THR_POWER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_THR_STRONG: thr_strong_q <= cfg_data;
				CFG_THR_COLOR:  thr_color_q  <= cfg_data;
				CFG_THR_POWER:  thr_power_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lamp_on_q  <= 1'b1;
			level_q    <= LVL_ASLEEP;
			idle_q     <= '0;
			prog_q     <= '0;
			off_idle_q <= '0;
			bright_q   <= '0;
			br_down_q  <= 1'b0;
			col_back_q <= 1'b0;
			rw_q       <= '0;
			rc_q       <= RATIO_FULL;
		end else if (accept) begin
			lamp_on_q  <= lamp_on_d;
			level_q    <= level_d;
			idle_q     <= idle_d;
			prog_q     <= prog_d;
			off_idle_q <= off_idle_d;
			bright_q   <= bright_d;
			br_down_q  <= br_down_d;
			col_back_q <= col_back_d;
			rw_q       <= rw_d;
			rc_q       <= rc_d;
		end
	end

	assign res.bright     = bright_d;
	assign res.ratio_warm = rw_d;
	assign res.ratio_cool = rc_d;
	assign res.beep       = beep;
	assign res.stop       = stop;

endmodule
`default_nettype wire

FILE: rtl/gldc_scale.sv
// Result pipeline: snapshot of the updated lamp state, brightness times ratio,
// then division by 100 into the PWM compare values. Depends on gldc_pkg.
`default_nettype none
module gldc_scale (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire gldc_pkg::gldc_res_t         res,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [gldc_pkg::PwmW-1:0]        pwm_warm,
	output logic [gldc_pkg::PwmW-1:0]        pwm_cool,
	output logic [gldc_pkg::CodeW-1:0]       beep_kind,
	output logic [gldc_pkg::CodeW-1:0]       stop_code
);
	import gldc_pkg::*;

	localparam int unsigned QW = ProdW + RecipW;

	logic       v_s1, v_s2, v_s3;
	logic       adv1, adv2, adv3;
	gldc_res_t  res_s1;
	logic [ProdW-1:0] pw_s2, pc_s2;
	logic [CodeW-1:0] beep_s2, stop_s2;
	logic [QW-1:0]    qw, qc;

	assign adv3 = !v_s3 || out_ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) res_s1 <= res;
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			pw_s2   <= ProdW'(res_s1.bright) * ProdW'(res_s1.ratio_warm);
			pc_s2   <= ProdW'(res_s1.bright) * ProdW'(res_s1.ratio_cool);
			beep_s2 <= res_s1.beep;
			stop_s2 <= res_s1.stop;
		end
	end

	assign qw = QW'(pw_s2) * QW'(RECIP_100);
	assign qc = QW'(pc_s2) * QW'(RECIP_100);

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			pwm_warm  <= qw[RECIP_SH +: PwmW];
			pwm_cool  <= qc[RECIP_SH +: PwmW];
			beep_kind <= beep_s2;
			stop_code <= stop_s2;
		end
	end

	assign out_valid = v_s3;

endmodule
`default_nettype wire

FILE: rtl/gesture_lamp_dimmer_controller_core.sv
// Gesture lamp dimmer controller, top level.
// Instantiates gldc_ctrl and gldc_scale; depends on gldc_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one classifier verdict per item:
//   three class scores from each of two windows, unsigned Q0.16.
//   Output channel (out_valid/out_ready) gives one result item per input
//   item: the warm and cool PWM compare values, a beep code and a stop code.
//   Configuration channel (cfg_valid/cfg_ready) writes the three thresholds
//   by index; it is always ready, and an index beyond the list is ignored.
//   Write it only while no item is in flight.
//   Throughput: one item per cycle while the receiver keeps out_ready high.
//   The lamp state is updated in the cycle an item is accepted; its result
//   then passes the snapshot, product and divide-by-100 stages in turn.
//   When the receiver stalls, the three result stages fill and then
//   in_ready drops; no item is lost or repeated.
//   Reset (arst_n low) restores the default thresholds, lamp on, asleep,
//   brightness 0, ratio 0/100, and empties the result stages.
`default_nettype none
module gesture_lamp_dimmer_controller_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [gldc_pkg::ScoreW-1:0]   bright_score_a,
	input  wire logic [gldc_pkg::ScoreW-1:0]   color_score_a,
	input  wire logic [gldc_pkg::ScoreW-1:0]   power_score_a,
	input  wire logic [gldc_pkg::ScoreW-1:0]   bright_score_b,
	input  wire logic [gldc_pkg::ScoreW-1:0]   color_score_b,
	input  wire logic [gldc_pkg::ScoreW-1:0]   power_score_b,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [gldc_pkg::PwmW-1:0]          pwm_warm,
	output logic [gldc_pkg::PwmW-1:0]          pwm_cool,
	output logic [gldc_pkg::CodeW-1:0]         beep_kind,
	output logic [gldc_pkg::CodeW-1:0]         stop_code,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [gldc_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [gldc_pkg::ScoreW-1:0]   cfg_data
);
	import gldc_pkg::*;

	gldc_res_t res;
	logic      accept;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	gldc_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.bright_score_a (bright_score_a),
		.color_score_a  (color_score_a),
		.power_score_a  (power_score_a),
		.bright_score_b (bright_score_b),
		.color_score_b  (color_score_b),
		.power_score_b  (power_score_b),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.res            (res)
	);

	gldc_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.res       (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pwm_warm  (pwm_warm),
		.pwm_cool  (pwm_cool),
		.beep_kind (beep_kind),
		.stop_code (stop_code)
	);

endmodule
`default_nettype wire

FILE: tb/sv/lamp_result_checker.sv
// Watches the verdict, result and threshold channels of the lamp dimmer core,
// predicts every result item from its own copy of the lamp state and compares.
// Depends on gldc_pkg for codes and constants.
module lamp_result_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic                          in_ready,
	input  wire logic [gldc_pkg::ScoreW-1:0]   bright_score_a,
	input  wire logic [gldc_pkg::ScoreW-1:0]   color_score_a,
	input  wire logic [gldc_pkg::ScoreW-1:0]   power_score_a,
	input  wire logic [gldc_pkg::ScoreW-1:0]   bright_score_b,
	input  wire logic [gldc_pkg::ScoreW-1:0]   color_score_b,
	input  wire logic [gldc_pkg::ScoreW-1:0]   power_score_b,
	input  wire logic                          out_valid,
	input  wire logic                          out_ready,
	input  wire logic [gldc_pkg::PwmW-1:0]     pwm_warm,
	input  wire logic [gldc_pkg::PwmW-1:0]     pwm_cool,
	input  wire logic [gldc_pkg::CodeW-1:0]    beep_kind,
	input  wire logic [gldc_pkg::CodeW-1:0]    stop_code,
	input  wire logic                          cfg_valid,
	input  wire logic                          cfg_ready,
	input  wire logic [gldc_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [gldc_pkg::ScoreW-1:0]   cfg_data,
	output int                                 n_fail,
	output int                                 n_pending
);
	import gldc_pkg::*;

	typedef struct {
		logic [PwmW-1:0]  warm;
		logic [PwmW-1:0]  cool;
		logic [CodeW-1:0] beep;
		logic [CodeW-1:0] stop;
	} lamp_out_t;

	logic [ScoreW-1:0]   thr_strong, thr_color, thr_power;
	logic                lamp_on;
	logic [LevelW-1:0]   wake;
	logic [IdleW-1:0]    idle_cnt;
	logic [ProgW-1:0]    progress;
	logic [OffIdleW-1:0] off_idle;
	logic                going_down, colour_back;
	int                  bright, warm, cool;

	lamp_out_t due_q [$];
	lamp_out_t want, got;
	int        n_seen;

	function automatic int ratio_up(int r);
		return (r + int'(COLOR_STEP) > int'(RATIO_FULL)) ? int'(RATIO_FULL) : r + int'(COLOR_STEP);
	endfunction

	function automatic int ratio_down(int r);
		return (r < int'(COLOR_STEP)) ? 0 : r - int'(COLOR_STEP);
	endfunction

	task automatic reset_lamp();
		thr_strong  = THR_STRONG_RST;
		thr_color   = THR_COLOR_RST;
		thr_power   = THR_POWER_RST;
		lamp_on     = 1'b1;
		wake        = LVL_ASLEEP;
		idle_cnt    = '0;
		progress    = '0;
		off_idle    = '0;
		going_down  = 1'b0;
		colour_back = 1'b0;
		bright      = 0;
		warm        = 0;
		cool        = int'(RATIO_FULL);
	endtask

	task automatic predict_lamp(input logic [ScoreW-1:0] ba, ca, pa, bb, cb, pb,
			output lamp_out_t r);
		logic br_s, co_s, pw_s, co_c, pw_p, motion;
		logic [CodeW-1:0] beep, stop;
		br_s   = ba > thr_strong && bb > thr_strong;
		co_s   = ca > thr_strong && cb > thr_strong;
		pw_s   = pa > thr_strong && pb > thr_strong;
		co_c   = ca > thr_color && cb > thr_color;
		pw_p   = pa > thr_power && pb > thr_power;
		motion = br_s || co_s || pw_s;
		beep   = BEEP_NONE;
		stop   = STOP_NONE;
		if (lamp_on) begin
			if (!motion) begin
				if (wake == LVL_WAKING) begin
					idle_cnt = idle_cnt + 1'b1;
					if (idle_cnt >= WAKE1_LIMIT) begin
						idle_cnt = '0;
						wake = LVL_ASLEEP;
					end
				end
				if (wake == LVL_AWAKE) begin
					idle_cnt = idle_cnt + 1'b1;
					if (idle_cnt > WAKE2_LIMIT) begin
						idle_cnt = '0;
						wake = LVL_ASLEEP;
					end
				end
			end else if (wake != LVL_ASLEEP) begin
				if (br_s) begin
					bright = going_down ? bright - int'(BRIGHT_STEP) : bright + int'(BRIGHT_STEP);
					if (bright > int'(BRIGHT_MAX)) begin
						going_down = 1'b1;
						bright = int'(BRIGHT_MAX);
					end
					if (bright < int'(BRIGHT_MIN)) begin
						going_down = 1'b0;
						bright = int'(BRIGHT_MIN);
					end
					beep = BEEP_SINGLE;
					stop = STOP_BRIGHT;
					wake = LVL_AWAKE;
				end else if (co_c) begin
					if (!colour_back) begin
						warm = ratio_up(warm);
						cool = ratio_down(cool);
					end else begin
						cool = ratio_up(cool);
						warm = ratio_down(warm);
					end
					if (warm == int'(RATIO_FULL) && cool == 0)
						colour_back = 1'b1;
					else if (cool == int'(RATIO_FULL) && warm == 0)
						colour_back = 1'b0;
					beep = BEEP_DOUBLE;
					stop = STOP_COLOR;
					wake = LVL_AWAKE;
				end else if (pw_p) begin
					if (wake == LVL_JUST_ON) begin
						wake = LVL_AWAKE;
					end else begin
						bright   = 0;
						warm     = int'(RATIO_HALF);
						cool     = int'(RATIO_HALF);
						progress = '0;
						lamp_on  = 1'b0;
						beep     = BEEP_LONG;
						wake     = LVL_AWAKE;
					end
				end
			end else begin
				if (br_s || co_c) begin
					wake = LVL_WAKING;
				end else if (pw_p) begin
					wake = LVL_WAKING;
					progress = '0;
					beep = BEEP_LONG;
				end
			end
		end else begin
			if (!motion) begin
				if (progress == 2'd1) begin
					off_idle = off_idle + 1'b1;
					if (off_idle >= OFF_IDLE_LIMIT) begin
						off_idle = '0;
						progress = '0;
					end
				end
			end else if (pw_p && progress < 2'd2) begin
				progress = progress + 1'b1;
				beep = BEEP_LONG;
				if (progress >= 2'd2) begin
					bright   = int'(BRIGHT_ON);
					warm     = int'(RATIO_HALF);
					cool     = int'(RATIO_HALF);
					lamp_on  = 1'b1;
					off_idle = '0;
					progress = '0;
					wake     = LVL_JUST_ON;
				end
			end
		end
		r.warm = PwmW'(bright * warm / 100);
		r.cool = PwmW'(bright * cool / 100);
		r.beep = beep;
		r.stop = stop;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_lamp();
			due_q.delete();
			n_pending = 0;
			n_fail = 0;
			n_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_THR_STRONG: thr_strong = cfg_data;
					CFG_THR_COLOR:  thr_color  = cfg_data;
					CFG_THR_POWER:  thr_power  = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got.warm = pwm_warm;
				got.cool = pwm_cool;
				got.beep = beep_kind;
				got.stop = stop_code;
				if (due_q.size() == 0) begin
					if (n_fail < 10)
						$display("result %0d with no item waiting: warm %0d cool %0d beep %0d stop %0d",
							n_seen, got.warm, got.cool, got.beep, got.stop);
					n_fail++;
				end else begin
					want = due_q.pop_front();
					if (got.warm !== want.warm || got.cool !== want.cool ||
							got.beep !== want.beep || got.stop !== want.stop) begin
						if (n_fail < 10)
							$display("result %0d: expected warm %0d cool %0d beep %0d stop %0d, got warm %0d cool %0d beep %0d stop %0d",
								n_seen, want.warm, want.cool, want.beep, want.stop,
								got.warm, got.cool, got.beep, got.stop);
						n_fail++;
					end
				end
				n_seen++;
			end
			if (in_valid && in_ready) begin
				predict_lamp(bright_score_a, color_score_a, power_score_a,
					bright_score_b, color_score_b, power_score_b, want);
				due_q.push_back(want);
			end
			n_pending = due_q.size();
		end
	end

endmodule

FILE: tb/sv/testbench.sv
// Top of the lamp dimmer core test: clock, reset, verdict and threshold stimulus
// with random gaps and stalls, and the final verdict.
// Depends on gldc_pkg, gesture_lamp_dimmer_controller_core and lamp_result_checker.
module testbench;
	import gldc_pkg::*;

	localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;
	localparam logic [ScoreW-1:0]  HI = 16'hFFFF;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [ScoreW-1:0] bright_score_a = '0, color_score_a = '0, power_score_a = '0;
	logic [ScoreW-1:0] bright_score_b = '0, color_score_b = '0, power_score_b = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [PwmW-1:0]  pwm_warm, pwm_cool;
	logic [CodeW-1:0] beep_kind, stop_code;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [ScoreW-1:0]  cfg_data = '0;

	int n_fail, n_pending;
	int sender_burst = 0;
	int recv_burst = 0;
	int unsigned lim_strong = THR_STRONG_RST;
	int unsigned lim_color  = THR_COLOR_RST;
	int unsigned lim_power  = THR_POWER_RST;

	gesture_lamp_dimmer_controller_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.bright_score_a(bright_score_a), .color_score_a(color_score_a),
		.power_score_a(power_score_a), .bright_score_b(bright_score_b),
		.color_score_b(color_score_b), .power_score_b(power_score_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.pwm_warm(pwm_warm), .pwm_cool(pwm_cool),
		.beep_kind(beep_kind), .stop_code(stop_code),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	lamp_result_checker lamp_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.bright_score_a(bright_score_a), .color_score_a(color_score_a),
		.power_score_a(power_score_a), .bright_score_b(bright_score_b),
		.color_score_b(color_score_b), .power_score_b(power_score_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.pwm_warm(pwm_warm), .pwm_cool(pwm_cool),
		.beep_kind(beep_kind), .stop_code(stop_code),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.n_fail(n_fail), .n_pending(n_pending)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int draw_wait(inout int burst);
		int w;
		if (burst > 0) begin
			burst--;
			w = 0;
		end else if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(20, 60);
			w = 0;
		end else begin
			w = $urandom_range(0, 13);
		end
		return w;
	endfunction

	function automatic logic [ScoreW-1:0] above(int unsigned thr);
		logic [ScoreW-1:0] v;
		if (thr >= 65535) begin
			v = HI;
		end else begin
			case ($urandom_range(0, 7))
				0, 1: v = ScoreW'(thr + 1);
				2: v = HI;
				default: v = ScoreW'($urandom_range(65535, thr + 1));
			endcase
		end
		return v;
	endfunction

	function automatic logic [ScoreW-1:0] below(int unsigned thr);
		logic [ScoreW-1:0] v;
		if ($urandom_range(0, 3) == 0)
			v = ScoreW'(thr);
		else
			v = ScoreW'($urandom_range(thr, 0));
		return v;
	endfunction

	function automatic int unsigned min_thr();
		int unsigned m;
		m = lim_strong;
		if (lim_color < m) m = lim_color;
		if (lim_power < m) m = lim_power;
		return m;
	endfunction

	function automatic int unsigned class_thr(int c);
		int unsigned t;
		case (c)
			0: t = lim_strong;
			1: t = lim_color;
			default: t = lim_power;
		endcase
		return t;
	endfunction

	task automatic push_verdict(input logic [ScoreW-1:0] ba, ca, pa, bb, cb, pb);
		int gap;
		gap = draw_wait(sender_burst);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		bright_score_a <= ba;
		color_score_a  <= ca;
		power_score_a  <= pa;
		bright_score_b <= bb;
		color_score_b  <= cb;
		power_score_b  <= pb;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_pair(input logic [ScoreW-1:0] b, c, p);
		push_verdict(b, c, p, b, c, p);
	endtask

	task automatic push_idle();
		int unsigned m;
		m = min_thr();
		push_verdict(below(m), below(m), below(m), below(m), below(m), below(m));
	endtask

	task automatic push_random();
		logic [ScoreW-1:0] s [6];
		int unsigned m, thr;
		int k, c;
		m = min_thr();
		for (int i = 0; i < 6; i++) s[i] = below(m);
		k = $urandom_range(0, 99);
		c = $urandom_range(0, 2);
		thr = class_thr(c);
		if ($urandom_range(0, 3) != 0 && lim_strong > thr)
			thr = lim_strong;
		if (k < 30) begin
		end else if (k < 82) begin
			s[c] = above(thr);
			s[c + 3] = above(thr);
		end else if (k < 90) begin
			if ($urandom_range(0, 1) == 1)
				s[c] = above(thr);
			else
				s[c + 3] = above(thr);
		end else begin
			for (int i = 0; i < 6; i++) begin
				thr = class_thr($urandom_range(0, 2));
				case ($urandom_range(0, 2))
					0: s[i] = ScoreW'($urandom);
					1: s[i] = above(thr);
					default: s[i] = below(thr);
				endcase
			end
		end
		push_verdict(s[0], s[1], s[2], s[3], s[4], s[5]);
	endtask

	task automatic run_random(input int count);
		int n, run;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 19) == 0) begin
				run = $urandom_range(4, 12);
				repeat (run) push_idle();
				n += run;
			end else begin
				push_random();
				n++;
			end
		end
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (n_pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_thr(input logic [CfgIdxW-1:0] idx, input logic [ScoreW-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_THR_STRONG: lim_strong = val;
			CFG_THR_COLOR:  lim_color  = val;
			CFG_THR_POWER:  lim_power  = val;
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [ScoreW-1:0] s, c, p);
		write_thr(CFG_THR_STRONG, s);
		write_thr(CFG_THR_COLOR, c);
		write_thr(CFG_THR_POWER, p);
	endtask

	initial begin
		int hold, taken;
		taken = 0;
		wait (arst_n === 1'b1);
		forever begin
			hold = draw_wait(recv_burst);
			if (taken == 150 || taken == 600)
				hold = 80;
			@(negedge clk);
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
		end
	end

	initial begin
		#4000000;
		$display("gesture_lamp_dimmer_controller_core test failed");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_pair('0, '0, '0);
		send_pair(THR_STRONG_RST, '0, '0);
		send_pair('0, '0, HI);
		send_pair(THR_STRONG_RST + 1'b1, '0, '0);
		send_pair(HI, HI, HI);
		repeat (4) send_pair(HI, '0, '0);
		send_pair('0, THR_STRONG_RST + 1'b1, '0);
		send_pair('0, HI, '0);
		send_pair('0, THR_COLOR_RST + 1'b1, '0);
		push_verdict('0, '0, HI, '0, '0, '0);
		send_pair('0, '0, HI);
		send_pair(HI, HI, '0);
		send_pair('0, '0, HI);
		send_pair('0, '0, HI);
		send_pair('0, '0, HI);
		send_pair('0, '0, HI);
		send_pair('0, '0, HI);
		repeat (5) send_pair('0, '0, '0);
		send_pair('0, '0, HI);

		run_random(250);
		settle();
		write_thr(CFG_UNUSED, ScoreW'($urandom));
		write_all('0, '0, '0);
		run_random(120);
		settle();
		write_all(HI, HI, HI);
		run_random(60);
		settle();
		write_all(16'd30000, 16'd50000, 16'd60000);
		run_random(200);
		settle();
		write_all(ScoreW'($urandom_range(40000, 65535)), ScoreW'($urandom),
			ScoreW'($urandom));
		run_random(220);
		settle();
		repeat (8) @(negedge clk);

		if (n_fail == 0 && n_pending == 0)
			$display("gesture_lamp_dimmer_controller_core test passed");
		else
			$display("gesture_lamp_dimmer_controller_core test failed");
		$finish;
	end

endmodule
